// File: rtl/core/pfde_pkg.sv
// Shared definitions for the palette frame buffer draw engine.
// Operation codes, default frame size, output queue sizing and the palette ROM.
// No dependencies.
package pfde_pkg;

    localparam int FRAME_WIDTH_DEF  = 160;
    localparam int FRAME_HEIGHT_DEF = 128;

    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_PIXEL      = 3'd0;
    localparam logic [OP_W-1:0] OP_RECT       = 3'd1;
    localparam logic [OP_W-1:0] OP_SPRITE     = 3'd2;
    localparam logic [OP_W-1:0] OP_SPRITE_PIX = 3'd3;
    localparam logic [OP_W-1:0] OP_SCAN       = 3'd4;

    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

    // Scanout read tag, aligned with the store's registered read data
    typedef struct packed {
        logic valid;
        logic last;
    } scan_tag_t;

    localparam int PALETTE_USED = 72;

    localparam logic [15:0] PALETTE_ROM [PALETTE_USED] = '{
        16'h0000, 16'h0000, 16'hffff, 16'hf800, 16'h07e0, 16'h001f, 16'hffff, 16'hffff,
        16'h4167, 16'h59a8, 16'h7a29, 16'ha2ca, 16'hbbcb, 16'hed0c, 16'hf674, 16'hb6a7,
        16'h7546, 16'h3bc8, 16'h3aca, 16'h3165, 16'h5a8a, 16'h7b8e, 16'ha491, 16'hce37,
        16'hdfbe, 16'h8f5e, 16'h2e7b, 16'h3bd5, 16'h3a2f, 16'h3989, 16'h520c, 16'h8a31,
        16'hcb12, 16'hfd76, 16'hf5a3, 16'hf3e3, 16'he245, 16'ha9c7, 16'h8392, 16'h4aad,
        16'h20a3, 16'h28c4, 16'h3904, 16'h5165, 16'h59e5, 16'h7286, 16'h7b2a, 16'h5b43,
        16'h3aa3, 16'h19e4, 16'h1965, 16'h18a2, 16'h2945, 16'h39c7, 16'h5248, 16'h630b,
        16'h6bcf, 16'h43af, 16'h132d, 16'h19ea, 16'h1907, 16'h18c4, 16'h2906, 16'h4127,
        16'h6189, 16'h7aab, 16'h7ac1, 16'h79e1, 16'h7122, 16'h50e3, 16'h41c9, 16'h2146
    };

    // Indexes past the populated part of the ROM read as black
    function automatic logic [15:0] palette_lookup(input logic [7:0] idx);
        logic [15:0] color;
        color = 16'h0000;
        if (idx < 8'(PALETTE_USED))
        begin
            color = PALETTE_ROM[idx[6:0]];
        end
        return color;
    endfunction

endpackage

// File: rtl/core/pfde_store.sv
// Frame store: one 8-bit palette index per pixel, row-major.
// Single write port, single read port with registered read data. Uses pfde_pkg.
module pfde_store
    import pfde_pkg::*;
#(
    parameter int DEPTH  = FRAME_WIDTH_DEF * FRAME_HEIGHT_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [7:0]        wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [7:0]        rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/pfde_draw.sv
// Command stage of the draw engine: pixel, rectangle walker, sprite cursor,
// scanout read issue and the clearing sweep after reset. Drives pfde_store. Uses pfde_pkg.
module pfde_draw
    import pfde_pkg::*;
#(
    parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF,
    parameter int ADDR_W       = $clog2(FRAME_WIDTH * FRAME_HEIGHT)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [OP_W-1:0]   op,
    input  logic [7:0]        x_pos,
    input  logic [7:0]        y_pos,
    input  logic [7:0]        width,
    input  logic [7:0]        height,
    input  logic [7:0]        pen_index,
    output logic              busy,
    output logic              we,
    output logic [ADDR_W-1:0] waddr,
    output logic [7:0]        wdata,
    output logic              re,
    output logic [ADDR_W-1:0] raddr,
    output scan_tag_t         tag
);

    localparam int CELLS = FRAME_WIDTH * FRAME_HEIGHT;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(FRAME_WIDTH);
    localparam logic [8:0] COLS   = 9'(FRAME_WIDTH);
    localparam logic [8:0] ROWS   = 9'(FRAME_HEIGHT);
    localparam logic [8:0] COL_MAX = 9'(FRAME_WIDTH - 1);
    localparam logic [8:0] ROW_MAX = 9'(FRAME_HEIGHT - 1);

    // command stage
    logic            cmd_valid_reg;
    logic [OP_W-1:0] cmd_op_reg;
    logic [7:0]      cmd_x_reg;
    logic [7:0]      cmd_y_reg;
    logic [7:0]      cmd_w_reg;
    logic [7:0]      cmd_h_reg;
    logic [7:0]      cmd_idx_reg;

    // clearing sweep
    logic              clear_active_reg;
    logic [ADDR_W-1:0] clear_addr_reg;

    // rectangle walker
    logic              walk_busy_reg;
    logic [7:0]        walk_col_reg;
    logic [7:0]        walk_row_reg;
    logic [7:0]        walk_x0_reg;
    logic [7:0]        walk_end_col_reg;
    logic [7:0]        walk_end_row_reg;
    logic [7:0]        walk_idx_reg;
    logic [ADDR_W-1:0] walk_addr_reg;
    logic [ADDR_W-1:0] walk_base_reg;

    // sprite
    logic [7:0] spr_ox_reg;
    logic [7:0] spr_oy_reg;
    logic [7:0] spr_cols_reg;
    logic [7:0] spr_rows_reg;
    logic [7:0] spr_col_reg;
    logic [7:0] spr_row_reg;

    logic [ADDR_W-1:0] scan_pos_reg;
    scan_tag_t         tag_reg;

    logic              is_pixel;
    logic              is_rect;
    logic              is_sprite;
    logic              is_sprite_pix;
    logic              is_scan;
    logic              cmd_in_window;
    logic [ADDR_W-1:0] cmd_addr;
    logic              rect_ok;
    logic [8:0]        rect_end_col;
    logic [8:0]        rect_end_row;
    logic [8:0]        spr_abs_col;
    logic [8:0]        spr_abs_row;
    logic [ADDR_W-1:0] spr_addr;
    logic              spr_active;
    logic              spr_write;
    logic              spr_row_done;

    assign is_pixel      = cmd_valid_reg && (cmd_op_reg == OP_PIXEL);
    assign is_rect       = cmd_valid_reg && (cmd_op_reg == OP_RECT);
    assign is_sprite     = cmd_valid_reg && (cmd_op_reg == OP_SPRITE);
    assign is_sprite_pix = cmd_valid_reg && (cmd_op_reg == OP_SPRITE_PIX);
    assign is_scan       = cmd_valid_reg && (cmd_op_reg == OP_SCAN);

    assign cmd_in_window = ({1'b0, cmd_x_reg} < COLS) && ({1'b0, cmd_y_reg} < ROWS);
    assign cmd_addr      = ADDR_W'(cmd_y_reg) * ROW_STEP + ADDR_W'(cmd_x_reg);

    // rectangle clipped at the right and bottom edges
    assign rect_ok = cmd_in_window && (cmd_w_reg != 8'd0) && (cmd_h_reg != 8'd0);
    always_comb
    begin
        rect_end_col = {1'b0, cmd_x_reg} + {1'b0, cmd_w_reg} - 9'd1;
        rect_end_row = {1'b0, cmd_y_reg} + {1'b0, cmd_h_reg} - 9'd1;
        if (rect_end_col > COL_MAX)
        begin
            rect_end_col = COL_MAX;
        end
        if (rect_end_row > ROW_MAX)
        begin
            rect_end_row = ROW_MAX;
        end
    end

    assign spr_abs_col  = {1'b0, spr_ox_reg} + {1'b0, spr_col_reg};
    assign spr_abs_row  = {1'b0, spr_oy_reg} + {1'b0, spr_row_reg};
    assign spr_addr     = ADDR_W'(spr_abs_row) * ROW_STEP + ADDR_W'(spr_abs_col);
    assign spr_active   = (spr_cols_reg != 8'd0) && (spr_row_reg < spr_rows_reg);
    assign spr_write    = is_sprite_pix && spr_active && (cmd_idx_reg != 8'd0)
                          && (spr_abs_col < COLS) && (spr_abs_row < ROWS);
    assign spr_row_done = ({1'b0, spr_col_reg} + 9'd1) >= {1'b0, spr_cols_reg};

    // Hold the input side while clearing, while a rectangle sets up or walks
    assign busy = clear_active_reg || walk_busy_reg || is_rect;

    // write port; the sources never overlap
    always_comb
    begin
        we    = 1'b0;
        waddr = clear_addr_reg;
        wdata = 8'd0;
        priority if (clear_active_reg)
        begin
            we = 1'b1;
        end
        else if (walk_busy_reg)
        begin
            we    = 1'b1;
            waddr = walk_addr_reg;
            wdata = walk_idx_reg;
        end
        else if (is_pixel)
        begin
            we    = cmd_in_window;
            waddr = cmd_addr;
            wdata = cmd_idx_reg;
        end
        else if (is_sprite_pix)
        begin
            we    = spr_write;
            waddr = spr_addr;
            wdata = cmd_idx_reg;
        end
    end

    assign re    = is_scan;
    assign raddr = scan_pos_reg;
    assign tag   = tag_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_op_reg  <= op;
            cmd_x_reg   <= x_pos;
            cmd_y_reg   <= y_pos;
            cmd_w_reg   <= width;
            cmd_h_reg   <= height;
            cmd_idx_reg <= pen_index;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg    <= 1'b0;
            clear_active_reg <= 1'b1;
            clear_addr_reg   <= '0;
            walk_busy_reg    <= 1'b0;
            spr_ox_reg       <= 8'd0;
            spr_oy_reg       <= 8'd0;
            spr_cols_reg     <= 8'd0;
            spr_rows_reg     <= 8'd0;
            spr_col_reg      <= 8'd0;
            spr_row_reg      <= 8'd0;
            scan_pos_reg     <= '0;
            tag_reg          <= '0;
        end
        else
        begin
            cmd_valid_reg <= accept;

            if (clear_active_reg)
            begin
                if (clear_addr_reg == LAST_ADDR)
                begin
                    clear_active_reg <= 1'b0;
                end
                clear_addr_reg <= clear_addr_reg + ADDR_W'(1);
            end

            if (walk_busy_reg)
            begin
                if ((walk_col_reg == walk_end_col_reg) && (walk_row_reg == walk_end_row_reg))
                begin
                    walk_busy_reg <= 1'b0;
                end
            end
            else if (is_rect && rect_ok)
            begin
                walk_busy_reg <= 1'b1;
            end

            if (is_sprite)
            begin
                spr_ox_reg   <= cmd_x_reg;
                spr_oy_reg   <= cmd_y_reg;
                spr_cols_reg <= cmd_w_reg;
                spr_rows_reg <= cmd_h_reg;
                spr_col_reg  <= 8'd0;
                spr_row_reg  <= 8'd0;
            end
            else if (is_sprite_pix && spr_active)
            begin
                if (spr_row_done)
                begin
                    spr_col_reg <= 8'd0;
                    spr_row_reg <= spr_row_reg + 8'd1;
                end
                else
                begin
                    spr_col_reg <= spr_col_reg + 8'd1;
                end
            end

            tag_reg.valid <= is_scan;
            tag_reg.last  <= is_scan && (scan_pos_reg == LAST_ADDR);
            if (is_scan)
            begin
                scan_pos_reg <= (scan_pos_reg == LAST_ADDR) ? '0 : scan_pos_reg + ADDR_W'(1);
            end
        end
    end

    // walk the clipped rectangle row-major, one cell per cycle; walker fields need no reset
    always_ff @(posedge clk)
    begin
        if (walk_busy_reg)
        begin
            if (walk_col_reg == walk_end_col_reg)
            begin
                walk_row_reg  <= walk_row_reg + 8'd1;
                walk_col_reg  <= walk_x0_reg;
                walk_base_reg <= walk_base_reg + ROW_STEP;
                walk_addr_reg <= walk_base_reg + ROW_STEP;
            end
            else
            begin
                walk_col_reg  <= walk_col_reg + 8'd1;
                walk_addr_reg <= walk_addr_reg + ADDR_W'(1);
            end
        end
        else if (is_rect)
        begin
            walk_col_reg     <= cmd_x_reg;
            walk_row_reg     <= cmd_y_reg;
            walk_x0_reg      <= cmd_x_reg;
            walk_end_col_reg <= rect_end_col[7:0];
            walk_end_row_reg <= rect_end_row[7:0];
            walk_idx_reg     <= cmd_idx_reg;
            walk_addr_reg    <= cmd_addr;
            walk_base_reg    <= cmd_addr;
        end
    end

endmodule

// File: rtl/core/pfde_outq.sv
// Scanout result path: palette lookup of the store's read data and a small
// output queue with credit tracking for results still in flight. Uses pfde_pkg.
module pfde_outq
    import pfde_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       reserve,
    input  scan_tag_t  tag,
    input  logic [7:0] rdata,
    output logic       space,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [15:0] m_tdata,
    output logic       m_tlast
);

    logic [15:0]           q_data_reg [OUTQ_DEPTH];
    logic                  q_last_reg [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0] wr_ptr_reg;
    logic [OUTQ_PTR_W-1:0] rd_ptr_reg;
    logic [OUTQ_CNT_W-1:0] count_reg;
    logic [OUTQ_CNT_W-1:0] credit_reg;
    logic [OUTQ_CNT_W-1:0] credit_next;
    logic                  pop;

    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = q_data_reg[rd_ptr_reg];
    assign m_tlast  = q_last_reg[rd_ptr_reg];
    assign pop      = m_tvalid && m_tready;

    // Credits count results from input transfer until output transfer
    assign space = credit_reg < OUTQ_CNT_W'(OUTQ_DEPTH);

    always_comb
    begin
        credit_next = credit_reg;
        if (reserve && !pop)
        begin
            credit_next = credit_reg + OUTQ_CNT_W'(1);
        end
        else if (!reserve && pop)
        begin
            credit_next = credit_reg - OUTQ_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (tag.valid)
        begin
            q_data_reg[wr_ptr_reg] <= palette_lookup(rdata);
            q_last_reg[wr_ptr_reg] <= tag.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            credit_reg <= '0;
        end
        else
        begin
            credit_reg <= credit_next;
            if (tag.valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + OUTQ_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + OUTQ_PTR_W'(1);
            end
            if (tag.valid && !pop)
            begin
                count_reg <= count_reg + OUTQ_CNT_W'(1);
            end
            else if (!tag.valid && pop)
            begin
                count_reg <= count_reg - OUTQ_CNT_W'(1);
            end
        end
    end

endmodule

// File: rtl/core/palette_framebuffer_draw_engine.sv
// Indexed-color frame buffer with pixel, rectangle and sprite drawing and RGB565 scanout.
// Pixel, sprite and scanout commands can be taken back to back while the output queue has
// space; a scanout result passes the command register, the store's registered read and the
// output queue before it is valid. A rectangle holds s_tready low while it sets up and while
// it walks its clipped area through the single write port of the frame store. After reset
// the store is swept to index 0, one cell per cycle, with s_tready low. Depends on pfde_pkg,
// pfde_draw, pfde_store and pfde_outq.
module palette_framebuffer_draw_engine
    import pfde_pkg::*;
#(
    parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // x_pos[7:0], y_pos[15:8], width[23:16], height[31:24],
                                   // pen_index[39:32]
    input  logic [2:0]  s_tuser,   // op[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // rgb565[15:0]
    output logic        m_tlast    // frame_last
);

    localparam int CELLS  = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int ADDR_W = $clog2(CELLS);

    logic              accept;
    logic              busy;
    logic              space;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
    logic [7:0]        rdata;
    scan_tag_t         tag;

    assign s_tready = !busy && space;
    assign accept   = s_tvalid && s_tready;

    pfde_draw #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT),
        .ADDR_W       (ADDR_W)
    ) u_draw (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .op          (s_tuser),
        .x_pos       (s_tdata[7:0]),
        .y_pos       (s_tdata[15:8]),
        .width       (s_tdata[23:16]),
        .height      (s_tdata[31:24]),
        .pen_index   (s_tdata[39:32]),
        .busy        (busy),
        .we          (we),
        .waddr       (waddr),
        .wdata       (wdata),
        .re          (re),
        .raddr       (raddr),
        .tag         (tag)
    );

    pfde_store #(
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    pfde_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .reserve  (accept && (s_tuser == OP_SCAN)),
        .tag      (tag),
        .rdata    (rdata),
        .space    (space),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for palette_framebuffer_draw_engine: draws pixels, rectangles
// and sprites, scans the frame out and checks every RGB565 transfer against a shadow model.
// Depends on pfde_pkg and the RTL of the draw engine.
module tb;
    import pfde_pkg::*;

    localparam int FRAME_W      = FRAME_WIDTH_DEF;
    localparam int FRAME_H      = FRAME_HEIGHT_DEF;
    localparam int FRAME_CELLS  = FRAME_W * FRAME_H;
    localparam int RANDOM_ITEMS = 900;
    localparam int TAIL_SCANS   = 16;
    localparam int DRAIN_CYCLES = 50;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int COLORS_USED  = 72;

    localparam logic [OP_W-1:0] OP_UNDEF_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_UNDEF_HI = 3'd7;

    localparam logic [15:0] COLOR_TABLE [COLORS_USED] = '{
        16'h0000, 16'h0000, 16'hffff, 16'hf800, 16'h07e0, 16'h001f, 16'hffff, 16'hffff,
        16'h4167, 16'h59a8, 16'h7a29, 16'ha2ca, 16'hbbcb, 16'hed0c, 16'hf674, 16'hb6a7,
        16'h7546, 16'h3bc8, 16'h3aca, 16'h3165, 16'h5a8a, 16'h7b8e, 16'ha491, 16'hce37,
        16'hdfbe, 16'h8f5e, 16'h2e7b, 16'h3bd5, 16'h3a2f, 16'h3989, 16'h520c, 16'h8a31,
        16'hcb12, 16'hfd76, 16'hf5a3, 16'hf3e3, 16'he245, 16'ha9c7, 16'h8392, 16'h4aad,
        16'h20a3, 16'h28c4, 16'h3904, 16'h5165, 16'h59e5, 16'h7286, 16'h7b2a, 16'h5b43,
        16'h3aa3, 16'h19e4, 16'h1965, 16'h18a2, 16'h2945, 16'h39c7, 16'h5248, 16'h630b,
        16'h6bcf, 16'h43af, 16'h132d, 16'h19ea, 16'h1907, 16'h18c4, 16'h2906, 16'h4127,
        16'h6189, 16'h7aab, 16'h7ac1, 16'h79e1, 16'h7122, 16'h50e3, 16'h41c9, 16'h2146
    };

    typedef struct {
        logic [OP_W-1:0] op;
        logic [7:0]      x;
        logic [7:0]      y;
        logic [7:0]      w;
        logic [7:0]      h;
        logic [7:0]      idx;
        bit              typed;
        logic [15:0]     rgb;
        logic            last;
    } draw_cmd_t;

    typedef struct {
        logic [15:0] rgb;
        logic        last;
    } scan_px_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;   // x_pos, y_pos, width, height, pen_index
    logic [2:0]  s_tuser  = '0;   // op
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // rgb565
    logic        m_tlast;         // frame_last

    // Shadow of the block's state
    logic [7:0]  shadow_pixels [FRAME_CELLS];
    logic [7:0]  spr_org_x, spr_org_y, spr_cols, spr_rows, spr_col, spr_row;
    logic [14:0] scan_pos;

    scan_px_t    expected_scan_q [$];
    scan_px_t    oldest_px;
    draw_cmd_t   directed_q [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int error_count    = 0;
    int item_count     = 0;
    int pixels_checked = 0;
    int frames_seen    = 0;
    int cycle_count    = 0;

    palette_framebuffer_draw_engine u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    function automatic logic [15:0] palette_color(input logic [7:0] idx);
        logic [15:0] color;
        color = 16'h0000;
        if (int'(idx) < COLORS_USED)
        begin
            color = COLOR_TABLE[idx];
        end
        return color;
    endfunction

    function automatic void plot_pixel(input int col, input int row, input logic [7:0] idx);
        if (col < FRAME_W && row < FRAME_H)
        begin
            shadow_pixels[row * FRAME_W + col] = idx;
        end
    endfunction

    // Apply one command to the shadow state; flag a scanout pixel or an ignored command
    task automatic predict_draw(input draw_cmd_t cmd, output bit has_px, output bit ignored,
                                output scan_px_t px);
        int last_cell;
        has_px    = 1'b0;
        ignored   = 1'b0;
        px        = '{16'h0000, 1'b0};
        last_cell = FRAME_CELLS - 1;
        case (cmd.op)
            OP_PIXEL:
            begin
                plot_pixel(int'(cmd.x), int'(cmd.y), cmd.idx);
            end
            OP_RECT:
            begin
                for (int r = 0; r < int'(cmd.h); r++)
                begin
                    if (int'(cmd.y) + r >= FRAME_H)
                    begin
                        break;
                    end
                    for (int c = 0; c < int'(cmd.w); c++)
                    begin
                        if (int'(cmd.x) + c >= FRAME_W)
                        begin
                            break;
                        end
                        plot_pixel(int'(cmd.x) + c, int'(cmd.y) + r, cmd.idx);
                    end
                end
            end
            OP_SPRITE:
            begin
                spr_org_x = cmd.x;
                spr_org_y = cmd.y;
                spr_cols  = cmd.w;
                spr_rows  = cmd.h;
                spr_col   = '0;
                spr_row   = '0;
            end
            OP_SPRITE_PIX:
            begin
                if (spr_cols == 0 || spr_row >= spr_rows)
                begin
                    ignored = 1'b1;
                end
                else
                begin
                    // Index 0 is transparent; the cursor still advances
                    if (cmd.idx != 0)
                    begin
                        plot_pixel(int'(spr_org_x) + int'(spr_col),
                                   int'(spr_org_y) + int'(spr_row), cmd.idx);
                    end
                    spr_col = spr_col + 8'd1;
                    if (spr_col >= spr_cols)
                    begin
                        spr_col = '0;
                        spr_row = spr_row + 8'd1;
                    end
                end
            end
            OP_SCAN:
            begin
                if (int'(scan_pos) > last_cell)
                begin
                    scan_pos = '0;
                end
                has_px  = 1'b1;
                px.rgb  = palette_color(shadow_pixels[scan_pos]);
                px.last = (int'(scan_pos) == last_cell);
                scan_pos = px.last ? 15'd0 : scan_pos + 15'd1;
            end
            default:
            begin
                ignored = 1'b1;
            end
        endcase
    endtask

    // Present one command, hold it until the transfer, then update the shadow
    task automatic send_cmd(input draw_cmd_t cmd);
        bit       has_px;
        bit       ignored;
        scan_px_t px;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd.op;
        s_tdata  <= {cmd.idx, cmd.h, cmd.w, cmd.y, cmd.x};
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        predict_draw(cmd, has_px, ignored, px);
        if (has_px)
        begin
            if (cmd.typed)
            begin
                px.rgb  = cmd.rgb;
                px.last = cmd.last;
            end
            expected_scan_q.push_back(px);
        end
        if (!ignored)
        begin
            item_count++;
        end
    endtask

    function automatic draw_cmd_t make_cmd(input logic [OP_W-1:0] op, input int x, input int y,
                                           input int w, input int h, input int idx);
        draw_cmd_t cmd;
        cmd.op    = op;
        cmd.x     = 8'(x);
        cmd.y     = 8'(y);
        cmd.w     = 8'(w);
        cmd.h     = 8'(h);
        cmd.idx   = 8'(idx);
        cmd.typed = 1'b0;
        cmd.rgb   = '0;
        cmd.last  = 1'b0;
        return cmd;
    endfunction

    function automatic void add_row(input logic [OP_W-1:0] op, input int x, input int y,
                                    input int w, input int h, input int idx);
        directed_q.push_back(make_cmd(op, x, y, w, h, idx));
    endfunction

    function automatic void add_scan_row(input logic [15:0] rgb);
        draw_cmd_t cmd;
        cmd       = make_cmd(OP_SCAN, 255, 255, 255, 255, 255);
        cmd.typed = 1'b1;
        cmd.rgb   = rgb;
        cmd.last  = 1'b0;
        directed_q.push_back(cmd);
    endfunction

    function automatic int rand_coord(input int span);
        return ($urandom_range(0, 99) < 80) ? $urandom_range(0, span - 1) : $urandom_range(0, 255);
    endfunction

    function automatic int rand_color();
        return ($urandom_range(0, 99) < 65) ? $urandom_range(0, COLORS_USED - 1)
                                            : $urandom_range(0, 255);
    endfunction

    function automatic draw_cmd_t rand_filler(input logic [OP_W-1:0] op, input int idx);
        return make_cmd(op, $urandom_range(0, 255), $urandom_range(0, 255),
                        $urandom_range(0, 255), $urandom_range(0, 255), idx);
    endfunction

    task automatic set_idling(input int phase);
        case (phase)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 77; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 77; end
            default: begin send_idle_pct = 35; recv_stall_pct = 35; end
        endcase
    endtask

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_scan_q.size() == 0)
            begin
                $error("scanout transfer with no pixel pending: rgb565 %h frame_last %b",
                       m_tdata, m_tlast);
                error_count++;
            end
            else
            begin
                oldest_px = expected_scan_q.pop_front();
                pixels_checked++;
                if (m_tlast)
                begin
                    frames_seen++;
                end
                if (m_tdata !== oldest_px.rgb)
                begin
                    $error("rgb565 expected %h actual %h", oldest_px.rgb, m_tdata);
                    error_count++;
                end
                if (m_tlast !== oldest_px.last)
                begin
                    $error("frame_last expected %b actual %b", oldest_px.last, m_tlast);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        int        sel;
        int        kind;
        int        count;
        int        w;
        int        h;
        draw_cmd_t cmd;

        for (int i = 0; i < FRAME_CELLS; i++)
        begin
            shadow_pixels[i] = '0;
        end
        spr_org_x = '0;
        spr_org_y = '0;
        spr_cols  = '0;
        spr_rows  = '0;
        spr_col   = '0;
        spr_row   = '0;
        scan_pos  = '0;

        // Directed table: row 0 of the frame is read back through the scan position
        add_scan_row(16'h0000);
        add_row(OP_PIXEL, 1, 0, 0, 0, 3);
        add_scan_row(16'hf800);
        add_row(OP_RECT, 2, 0, 4, 1, 4);
        add_row(OP_PIXEL, 3, 0, 0, 0, 0);
        add_scan_row(16'h07e0);
        add_scan_row(16'h0000);
        add_row(OP_PIXEL, 4, 0, 0, 0, 255);
        add_scan_row(16'h0000);
        add_row(OP_PIXEL, 160, 0, 0, 0, 5);
        add_row(OP_PIXEL, 255, 255, 255, 255, 255);
        add_row(OP_RECT, 150, 120, 255, 255, 5);
        add_row(OP_RECT, 160, 0, 10, 10, 6);
        add_row(OP_RECT, 0, 128, 10, 10, 6);
        add_row(OP_RECT, 0, 0, 0, 5, 7);
        add_row(OP_RECT, 0, 0, 5, 0, 7);
        // Sprite straddling the bottom edge: one drawn, one transparent, two clipped
        add_row(OP_SPRITE, 158, 127, 2, 2, 0);
        add_row(OP_SPRITE_PIX, 0, 0, 0, 0, 9);
        add_row(OP_SPRITE_PIX, 0, 0, 0, 0, 0);
        add_row(OP_SPRITE_PIX, 0, 0, 0, 0, 12);
        add_row(OP_SPRITE_PIX, 0, 0, 0, 0, 13);
        add_row(OP_SPRITE_PIX, 0, 0, 0, 0, 14);
        add_row(OP_SPRITE, 0, 0, 0, 5, 0);
        add_row(OP_SPRITE_PIX, 0, 0, 0, 0, 15);
        add_row(OP_UNDEF_LO, 1, 1, 1, 1, 1);
        add_row(OP_RECT, 0, 0, 255, 255, 71);
        add_scan_row(16'h2146);

        set_idling(0);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_q[i])
        begin
            send_cmd(directed_q[i]);
        end
        item_count = 0;

        while (item_count < RANDOM_ITEMS)
        begin
            set_idling(item_count * 4 / RANDOM_ITEMS);
            sel = $urandom_range(0, 99);
            if (sel < 15)
            begin
                send_cmd(make_cmd(OP_PIXEL, rand_coord(FRAME_W), rand_coord(FRAME_H),
                                  $urandom_range(0, 255), $urandom_range(0, 255), rand_color()));
            end
            else if (sel < 30)
            begin
                // Mostly small rectangles; now and then one long side or a huge area
                kind = $urandom_range(0, 99);
                if (kind < 1)
                begin
                    w = $urandom_range(0, 255);
                    h = $urandom_range(0, 255);
                end
                else if (kind < 6)
                begin
                    w = $urandom_range(0, 255);
                    h = $urandom_range(0, 3);
                end
                else if (kind < 11)
                begin
                    w = $urandom_range(0, 3);
                    h = $urandom_range(0, 255);
                end
                else
                begin
                    w = $urandom_range(0, 8);
                    h = $urandom_range(0, 8);
                end
                send_cmd(make_cmd(OP_RECT, rand_coord(FRAME_W), rand_coord(FRAME_H),
                                  w, h, rand_color()));
            end
            else if (sel < 55)
            begin
                kind = $urandom_range(0, 99);
                if (kind < 5)
                begin
                    w = $urandom_range(0, 255);
                    h = $urandom_range(0, 2);
                end
                else if (kind < 10)
                begin
                    w = $urandom_range(0, 2);
                    h = $urandom_range(0, 255);
                end
                else
                begin
                    w = $urandom_range(0, 5);
                    h = $urandom_range(0, 5);
                end
                send_cmd(make_cmd(OP_SPRITE, rand_coord(FRAME_W), rand_coord(FRAME_H),
                                  w, h, $urandom_range(0, 255)));
                count = w * h;
                kind  = $urandom_range(0, 99);
                if (kind < 10)
                begin
                    count = $urandom_range(0, count);
                end
                else if (kind < 20)
                begin
                    count = count + $urandom_range(1, 3);
                end
                repeat (count)
                begin
                    send_cmd(rand_filler(OP_SPRITE_PIX,
                                         ($urandom_range(0, 99) < 30) ? 0 : rand_color()));
                end
            end
            else if (sel < 88)
            begin
                repeat ($urandom_range(1, 8))
                begin
                    send_cmd(rand_filler(OP_SCAN, $urandom_range(0, 255)));
                end
            end
            else if (sel < 95)
            begin
                send_cmd(rand_filler(OP_SPRITE_PIX, rand_color()));
            end
            else
            begin
                send_cmd(rand_filler(3'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI)),
                                     $urandom_range(0, 255)));
            end
        end

        // Scan a few more pixels with both sides idling
        set_idling(3);
        count = TAIL_SCANS;
        repeat (count)
        begin
            send_cmd(rand_filler(OP_SCAN, $urandom_range(0, 255)));
        end
        s_tvalid <= 1'b0;

        while (expected_scan_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d draw and scan commands after the directed table", item_count);
        $display("Checked %0d scanout pixels across %0d frame ends", pixels_checked, frames_seen);
        if (error_count == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: palette_framebuffer_draw_engine.f
rtl/core/pfde_pkg.sv
rtl/core/pfde_store.sv
rtl/core/pfde_draw.sv
rtl/core/pfde_outq.sv
rtl/core/palette_framebuffer_draw_engine.sv
tb/tb.sv
